// ===== hdl/quadtree_bitmap_decoder_macros.svh =====
// Assertion macros shared by the quadtree bitmap decoder modules.
// Standalone header; no other file is needed.
`ifndef QUADTREE_BITMAP_DECODER_MACROS_SVH
`define QUADTREE_BITMAP_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define QTBD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quadtree decoder: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define QTBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quadtree decoder: next-cycle check failed");

`endif

// ===== hdl/qtbd_pkg.sv =====
// Shared constants and types for the quadtree bitmap decoder.
// No dependencies.
package qtbd_pkg;

  localparam int SYMBOL_W   = 8;
  localparam int COORD_OUT_W = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_QUAD   = 4;

  // Code character that splits the current region
  localparam logic [SYMBOL_W-1:0] SPLIT_SYMBOL = 8'd68;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } cfg_reg_t;

  // Quadrant slots inside a push request
  localparam int QUAD_TL = 0;
  localparam int QUAD_TR = 1;
  localparam int QUAD_BL = 2;
  localparam int QUAD_BR = 3;

  // Stack status seen by the control logic
  typedef struct packed {
    logic empty;   // no pending region
    logic single;  // exactly one pending region
  } stk_status_t;

endpackage

// ===== hdl/qtbd_code_if.sv =====
// Symbol input channel of the quadtree bitmap decoder.
// Depends on qtbd_pkg.
interface qtbd_code_if;
  logic                          valid;
  logic                          ready;
  logic [qtbd_pkg::SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

// ===== hdl/qtbd_rect_if.sv =====
// Rectangle result channel of the quadtree bitmap decoder.
// Depends on qtbd_pkg.
interface qtbd_rect_if;
  logic                             valid;
  logic                             ready;
  logic [qtbd_pkg::COORD_OUT_W-1:0] row_first;
  logic [qtbd_pkg::COORD_OUT_W-1:0] row_end;
  logic [qtbd_pkg::COORD_OUT_W-1:0] col_first;
  logic [qtbd_pkg::COORD_OUT_W-1:0] col_end;
  logic [qtbd_pkg::SYMBOL_W-1:0]    fill_value;
  logic                             bitmap_done;

  modport source (output valid, output row_first, output row_end, output col_first,
                  output col_end, output fill_value, output bitmap_done, input ready);
  modport sink   (input valid, input row_first, input row_end, input col_first,
                  input col_end, input fill_value, input bitmap_done, output ready);
endinterface

// ===== hdl/qtbd_cfg_if.sv =====
// Configuration write channel of the quadtree bitmap decoder.
// Depends on qtbd_pkg.
interface qtbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qtbd_pkg::CFG_IDX_W-1:0]  index;
  logic [qtbd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/qtbd_quad_split.sv =====
// Quadrant split logic: midpoints of a region and its non-empty quadrants.
// Depends on qtbd_pkg.
module qtbd_quad_split #(
  parameter int CW = 8
) (
  input  logic [4*CW-1:0]                           region,
  input  logic [qtbd_pkg::SYMBOL_W-1:0]             symbol,
  output logic [qtbd_pkg::NUM_QUAD-1:0]             keep,
  output logic [qtbd_pkg::NUM_QUAD*4*CW-1:0]        quads,
  output logic                                      split
);

  typedef struct packed {
    logic [CW-1:0] r0;
    logic [CW-1:0] r1;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
  } region_t;

  region_t                              reg_in;
  region_t [qtbd_pkg::NUM_QUAD-1:0]     quad_r;
  logic [CW:0]                          row_sum;
  logic [CW:0]                          col_sum;
  logic [CW-1:0]                        row_mid;
  logic [CW-1:0]                        col_mid;
  logic [CW-1:0]                        row_low;
  logic [CW-1:0]                        col_low;
  logic                                 has_lower;
  logic                                 has_right;

  assign reg_in = region_t'(region);
  assign split  = (symbol == qtbd_pkg::SPLIT_SYMBOL);

  // Midpoints round down, so the upper and left halves take the extra line
  assign row_sum = {1'b0, reg_in.r0} + {1'b0, reg_in.r1};
  assign col_sum = {1'b0, reg_in.c0} + {1'b0, reg_in.c1};
  assign row_mid = row_sum[CW:1];
  assign col_mid = col_sum[CW:1];
  assign row_low = row_mid + CW'(1);
  assign col_low = col_mid + CW'(1);

  // A lower or right half exists only when the region spans more than one line
  assign has_lower = (reg_in.r0 != reg_in.r1);
  assign has_right = (reg_in.c0 != reg_in.c1);

  // Build the four quadrants
  always_comb begin
    quad_r[qtbd_pkg::QUAD_TL] = '{r0: reg_in.r0, r1: row_mid,   c0: reg_in.c0, c1: col_mid};
    quad_r[qtbd_pkg::QUAD_TR] = '{r0: reg_in.r0, r1: row_mid,   c0: col_low,   c1: reg_in.c1};
    quad_r[qtbd_pkg::QUAD_BL] = '{r0: row_low,   r1: reg_in.r1, c0: reg_in.c0, c1: col_mid};
    quad_r[qtbd_pkg::QUAD_BR] = '{r0: row_low,   r1: reg_in.r1, c0: col_low,   c1: reg_in.c1};
  end

  // Push only non-empty quadrants, and only on a split
  always_comb begin
    keep[qtbd_pkg::QUAD_TL] = split;
    keep[qtbd_pkg::QUAD_TR] = split && has_right;
    keep[qtbd_pkg::QUAD_BL] = split && has_lower;
    keep[qtbd_pkg::QUAD_BR] = split && has_lower && has_right;
  end

  assign quads = quad_r;

endmodule

// ===== hdl/qtbd_region_stack.sv =====
// Register stack of pending regions: pops the top and pushes up to four quadrants per cycle while en is high.
// Depends on qtbd_pkg and quadtree_bitmap_decoder_macros.svh.
`include "quadtree_bitmap_decoder_macros.svh"

module qtbd_region_stack #(
  parameter int CW          = 8,
  parameter int STACK_DEPTH = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [qtbd_pkg::NUM_QUAD-1:0]         keep,
  input  logic [qtbd_pkg::NUM_QUAD*4*CW-1:0]    quads,
  output logic [4*CW-1:0]                       top,
  output qtbd_pkg::stk_status_t                 status
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int PW = LW + 1;

  typedef struct packed {
    logic [CW-1:0] r0;
    logic [CW-1:0] r1;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
  } region_t;

  region_t                          entry [STACK_DEPTH];
  region_t [qtbd_pkg::NUM_QUAD-1:0] quad_r;
  logic [LW-1:0]                    level;
  logic [LW-1:0]                    level_next;
  logic [LW-1:0]                    base;
  logic [IW-1:0]                    top_idx;
  logic [PW-1:0]                    wr_pos [qtbd_pkg::NUM_QUAD];
  logic [PW-1:0]                    fill;

  assign quad_r = quads;

  assign status.empty  = (level == '0);
  assign status.single = (level == LW'(1));

  // Level after the pop; an empty stack pops nothing
  assign base    = status.empty ? '0 : level - LW'(1);
  assign top_idx = IW'(base);
  assign top     = entry[top_idx];

  // Place the kept quadrants from the bottom-right up, so upper-left lands on top
  always_comb begin
    logic [PW-1:0] acc;
    acc = PW'(base);
    for (int q = qtbd_pkg::NUM_QUAD - 1; q >= 0; q--) begin
      wr_pos[q] = acc;
      acc       = acc + PW'(keep[q]);
    end
    fill = acc;
  end

  // Pushes past the top are dropped
  assign level_next = (fill > PW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : LW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (en) begin
      level <= level_next;
    end
  end

  // Write the kept quadrants into their slots
  always_ff @(posedge clk) begin
    for (int e = 0; e < STACK_DEPTH; e++) begin
      for (int q = 0; q < qtbd_pkg::NUM_QUAD; q++) begin
        if (en && keep[q] && (wr_pos[q] == PW'(e))) begin
          entry[e] <= quad_r[q];
        end
      end
    end
  end

  `QTBD_ASSERT_SAME(a_level_bound, clk, rst, 1'b1, level <= LW'(STACK_DEPTH))
  `QTBD_ASSERT_NEXT(a_fill_pops, clk, rst, en && (keep == '0) && (level != '0), level == $past(level) - LW'(1))

endmodule

// ===== hdl/quadtree_bitmap_decoder.sv =====
// Quadtree bitmap decoder top level: input register, configuration, result register.
// Depends on qtbd_pkg, the channel interfaces, qtbd_quad_split, qtbd_region_stack
// and quadtree_bitmap_decoder_macros.svh.
//
// Usage:
//   code : one code character per transaction. 'D' splits the current region into
//          quadrants; any other value fills the region with that value.
//   rect : one transaction per fill character: the rectangle (inclusive bounds),
//          its fill value, and bitmap_done when the rectangle ends the bitmap.
//   cfg  : register writes, always ready. Index 0 sets rows, index 1 sets cols;
//          zero reads as 1, values above MAX_DIM read as MAX_DIM. A new value is
//          used when the next bitmap starts.
// Timing: a symbol is registered at acceptance and processed once the result
// register is free or being emptied; its rectangle is valid on rect the cycle
// after processing. One symbol per cycle is sustained while rect does not stall:
// the pop of the top region and the push of up to four quadrants into the register stack happen in the same cycle.
// Reset: the stack is emptied, rows and cols return to 1, no result is pending.
// Stall: a result waiting on rect blocks processing of the next symbol, which
// then holds in the input register; code stays ready while that register is free.
`include "quadtree_bitmap_decoder_macros.svh"

module quadtree_bitmap_decoder #(
  parameter int MAX_DIM     = 256,
  parameter int STACK_DEPTH = 25
) (
  input  logic          clk,
  input  logic          rst,
  qtbd_code_if.sink     code,
  qtbd_rect_if.source   rect,
  qtbd_cfg_if.sink      cfg
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int OW = qtbd_pkg::COORD_OUT_W;

  typedef struct packed {
    logic [CW-1:0] r0;
    logic [CW-1:0] r1;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
  } region_t;

  // Configuration
  logic [DW-1:0]                          rows;
  logic [DW-1:0]                          cols;
  logic [DW-1:0]                          cfg_dim;

  // Input register
  logic                                   sym_valid;
  logic [qtbd_pkg::SYMBOL_W-1:0]          sym;

  // Result register
  logic                                   res_valid;
  logic [OW-1:0]                          res_row_first;
  logic [OW-1:0]                          res_row_end;
  logic [OW-1:0]                          res_col_first;
  logic [OW-1:0]                          res_col_end;
  logic [qtbd_pkg::SYMBOL_W-1:0]          res_fill_value;
  logic                                   res_bitmap_done;

  // Processing
  logic                                   proc;
  logic                                   split;
  region_t                                cur;
  region_t                                stk_top;
  logic [4*CW-1:0]                        stk_top_bits;
  qtbd_pkg::stk_status_t                  stk_status;
  logic [qtbd_pkg::NUM_QUAD-1:0]          keep;
  logic [qtbd_pkg::NUM_QUAD*4*CW-1:0]     quads;

  // Configuration writes: clamp to 1..MAX_DIM
  assign cfg.ready = 1'b1;

  always_comb begin
    if (cfg.data == '0) begin
      cfg_dim = DW'(1);
    end else if (32'(cfg.data) > 32'(MAX_DIM)) begin
      cfg_dim = DW'(MAX_DIM);
    end else begin
      cfg_dim = DW'(cfg.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= DW'(1);
      cols <= DW'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        qtbd_pkg::REG_ROWS: rows <= cfg_dim;
        qtbd_pkg::REG_COLS: cols <= cfg_dim;
        default: ;
      endcase
    end
  end

  // Advance a symbol when the result register is free or being emptied
  assign proc       = sym_valid && (!res_valid || rect.ready);
  assign code.ready = !sym_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (code.valid && code.ready) begin
      sym_valid <= 1'b1;
    end else if (proc) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code.valid && code.ready) begin
      sym <= code.symbol;
    end
  end

  // Region under work: top of stack, or the whole bitmap when the stack is empty
  assign stk_top = region_t'(stk_top_bits);

  always_comb begin
    if (stk_status.empty) begin
      cur.r0 = '0;
      cur.r1 = CW'(rows - DW'(1));
      cur.c0 = '0;
      cur.c1 = CW'(cols - DW'(1));
    end else begin
      cur = stk_top;
    end
  end

  qtbd_quad_split #(
    .CW     (CW)
  ) u_split (
    .region (cur),
    .symbol (sym),
    .keep   (keep),
    .quads  (quads),
    .split  (split)
  );

  qtbd_region_stack #(
    .CW          (CW),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .rst    (rst),
    .en     (proc),
    .keep   (keep),
    .quads  (quads),
    .top    (stk_top_bits),
    .status (stk_status)
  );

  // Result register: load on a fill, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc && !split) begin
      res_valid <= 1'b1;
    end else if (rect.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !split) begin
      res_row_first   <= OW'(cur.r0);
      res_row_end     <= OW'(cur.r1);
      res_col_first   <= OW'(cur.c0);
      res_col_end     <= OW'(cur.c1);
      res_fill_value  <= sym;
      res_bitmap_done <= stk_status.empty || stk_status.single;
    end
  end

  assign rect.valid       = res_valid;
  assign rect.row_first   = res_row_first;
  assign rect.row_end     = res_row_end;
  assign rect.col_first   = res_col_first;
  assign rect.col_end     = res_col_end;
  assign rect.fill_value  = res_fill_value;
  assign rect.bitmap_done = res_bitmap_done;

  `QTBD_ASSERT_NEXT(a_fill_gives_result, clk, rst, proc && !split, res_valid)
  `QTBD_ASSERT_NEXT(a_split_no_result, clk, rst, proc && split, !res_valid)
  `QTBD_ASSERT_SAME(a_done_tracks_stack, clk, rst, res_valid, res_bitmap_done == stk_status.empty)

endmodule
